// ===== sv/wbps_pkg.sv =====
// Package for the wildcard byte pattern scan: default sizes, register map
// and configuration reset values. No dependencies.
package wbps_pkg;

  localparam int DEF_MAX_PATTERN_BYTES = 16;
  localparam int DEF_POSITION_BITS     = 32;

  localparam int PATTERN_SLOTS     = 16;
  localparam int LENGTH_FIELD_BITS = 5;
  localparam int ADDRESS_BITS      = 32;
  localparam int CFG_DATA_BITS     = 64;
  localparam int CFG_ADDR_BITS     = 6;
  localparam int CFG_INDEX_BITS    = 3;

  localparam logic [PATTERN_SLOTS-1:0]     MASK_RESET   = '1;
  localparam logic [LENGTH_FIELD_BITS-1:0] LENGTH_RESET = LENGTH_FIELD_BITS'(1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_COMPARE_MASK = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_RESULT_OFS   = 3'd4
  } cfg_reg_t;

endpackage

// ===== sv/wildcard_byte_pattern_scan.sv =====
// Wildcard byte pattern scan: image bytes in, one match or not-found beat
// out per image. Depends on wbps_pkg.
//
// The block takes one image byte per cycle and sustains that rate with both
// sides flowing. Each byte is registered, then compared combinationally
// against the window of the previous MAX_PATTERN_BYTES-1 bytes through a
// parallel per-lane compare, and the outcome lands in the result register.
// A stalled result holds the input stage, which then stalls the input.
// After the first result of an image, further bytes are absorbed without
// output until first_of_image.
// Configuration is a 64-bit APB port, register i at byte address 8*i.
module wildcard_byte_pattern_scan #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::DEF_MAX_PATTERN_BYTES,
  parameter int POSITION_BITS     = wbps_pkg::DEF_POSITION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wbps_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [wbps_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [wbps_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           image_byte,
  input  logic                                 first_of_image,
  input  logic                                 last_of_image,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 match_found,
  output logic [wbps_pkg::ADDRESS_BITS-1:0]    match_address
);
  import wbps_pkg::*;

  localparam int WIN_DEPTH = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
  localparam int HIST_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int LEN_BITS  = $clog2(MAX_PATTERN_BYTES + 1);

  logic [63:0]                    pattern_low;
  logic [63:0]                    pattern_high;
  logic [PATTERN_SLOTS-1:0]       compare_mask;
  logic [LENGTH_FIELD_BITS-1:0]   pattern_length;
  logic signed [ADDRESS_BITS-1:0] result_offset;

  logic                           cfg_write;
  cfg_reg_t                       cfg_sel;

  logic                           s1_valid;
  logic [7:0]                     s1_byte;
  logic                           s1_first;
  logic                           s1_last;

  logic [7:0]                     byte_window [WIN_DEPTH];
  logic [POSITION_BITS-1:0]       byte_position;
  logic                           scan_done;

  logic [7:0]                     win_eff     [WIN_DEPTH];
  logic [7:0]                     byte_window_next [WIN_DEPTH];
  logic [7:0]                     hist        [MAX_PATTERN_BYTES];
  logic [7:0]                     pat_bytes   [PATTERN_SLOTS];
  logic [LEN_BITS-1:0]            ages        [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0]   lane_ok;
  logic [LEN_BITS-1:0]            len;
  logic [LEN_BITS-1:0]            len_m1;
  logic [POSITION_BITS-1:0]       pos_eff;
  logic [POSITION_BITS-1:0]       start;
  logic                           done_eff;
  logic                           pos_ok;
  logic                           hit;
  logic                           blocked;
  logic                           proc;
  logic                           emit;
  logic [ADDRESS_BITS-1:0]        address_next;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:CFG_ADDR_BITS-CFG_INDEX_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      compare_mask   <= MASK_RESET;
      pattern_length <= LENGTH_RESET;
      result_offset  <= '0;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_PATTERN_LOW:  pattern_low    <= pwdata;
        REG_PATTERN_HIGH: pattern_high   <= pwdata;
        REG_COMPARE_MASK: compare_mask   <= pwdata[PATTERN_SLOTS-1:0];
        REG_PATTERN_LEN:  pattern_length <= pwdata[LENGTH_FIELD_BITS-1:0];
        REG_RESULT_OFS:   result_offset  <= signed'(pwdata[ADDRESS_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_PATTERN_LOW:  prdata = pattern_low;
      REG_PATTERN_HIGH: prdata = pattern_high;
      REG_COMPARE_MASK: prdata = CFG_DATA_BITS'(compare_mask);
      REG_PATTERN_LEN:  prdata = CFG_DATA_BITS'(pattern_length);
      REG_RESULT_OFS:   prdata = CFG_DATA_BITS'(unsigned'(result_offset));
      default:          prdata = '0;
    endcase
  end

  // handshake
  assign blocked  = out_valid && out_stall;
  assign in_stall = s1_valid && blocked;
  assign proc     = s1_valid && !blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte  <= image_byte;
      s1_first <= first_of_image;
      s1_last  <= last_of_image;
    end
  end

  // compare
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pat_bytes[i]     = pattern_low[8*i +: 8];
      pat_bytes[i + 8] = pattern_high[8*i +: 8];
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_BITS'(1);
    end else if (pattern_length > LENGTH_FIELD_BITS'(MAX_PATTERN_BYTES)) begin
      len = LEN_BITS'(MAX_PATTERN_BYTES);
    end else begin
      len = LEN_BITS'(pattern_length);
    end
  end

  assign len_m1   = len - LEN_BITS'(1);
  assign pos_eff  = s1_first ? '0 : byte_position;
  assign done_eff = !s1_first && scan_done;
  assign pos_ok   = pos_eff >= POSITION_BITS'(len_m1);

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_eff[i] = s1_first ? 8'd0 : byte_window[i];
    end
    hist[0] = s1_byte;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      hist[i] = win_eff[i-1];
    end
    byte_window_next[0] = s1_byte;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      byte_window_next[i] = win_eff[i-1];
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      ages[j] = len_m1 - LEN_BITS'(j);
      if ((LEN_BITS'(j) < len) && compare_mask[j]) begin
        lane_ok[j] = hist[ages[j][HIST_BITS-1:0]] == pat_bytes[j];
      end else begin
        lane_ok[j] = 1'b1;
      end
    end
  end

  assign hit          = pos_ok && (&lane_ok);
  assign start        = pos_eff - POSITION_BITS'(len_m1);
  assign address_next = ADDRESS_BITS'(start) + unsigned'(result_offset);
  assign emit         = proc && !done_eff && (hit || s1_last);

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        byte_window[i] <= 8'd0;
      end
      byte_position <= '0;
      scan_done     <= 1'b0;
    end else if (proc && !done_eff) begin
      byte_window   <= byte_window_next;
      byte_position <= pos_eff + POSITION_BITS'(1);
      scan_done     <= hit || s1_last;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      match_found   <= hit;
      match_address <= hit ? address_next : '0;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result without a registered byte");

  a_result_closes_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> scan_done)
    else $error("result given but scan left open");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !match_found) |-> (match_address == '0))
    else $error("not-found beat carries an address");

  a_no_emit_when_done: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && scan_done && !s1_first && !out_stall) |=> !$rose(out_valid))
    else $error("second result for one image");

endmodule
